/* sv/dew_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_pkg
// Types and codes shared by the depth-first edge walker modules.
// ----------------------------------------------------------------------------
package dew_pkg;

	localparam int FUNC_W = 2;
	localparam int VTX_W  = 5;
	localparam int KIND_W = 2;
	localparam int CNT_W  = 6;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [VTX_W-1:0]  vtx_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam func_t FUNC_CLEAR = 2'd0;
	localparam func_t FUNC_ADD   = 2'd1;
	localparam func_t FUNC_STEP  = 2'd2;

	localparam kind_t EVT_EDGE      = 2'd0;
	localparam kind_t EVT_COMP_DONE = 2'd1;
	localparam kind_t EVT_WALK_DONE = 2'd2;

	typedef struct packed {
		logic latch;
		logic clear;
		logic adj_rd_src;
		logic add_wr;
		logic step_init;
		logic emit_done;
		logic adj_rd_top;
		logic scan_adv;
		logic edge_emit;
		logic pop;
		logic top_ld;
		logic root_adv;
		logic root_take;
	} dew_cmd_t;

	typedef struct packed {
		logic phase_idle;
		logic phase_done;
		logic add_ok;
		logic out_free;
		logic level_zero;
		logic cur_end;
		logic row_hit;
		logic pop_last;
		logic root_end;
		logic root_hit;
	} dew_sts_t;

endpackage

/* sv/dew_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew channel interfaces
// Command, event and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dew_cmd_if;
	import dew_pkg::*;
	logic  valid;
	logic  ready;
	func_t func;
	vtx_t  src_vertex;
	vtx_t  dst_vertex;
	modport source (output valid, func, src_vertex, dst_vertex, input ready);
	modport sink (input valid, func, src_vertex, dst_vertex, output ready);
endinterface

interface dew_evt_if;
	import dew_pkg::*;
	logic  valid;
	logic  ready;
	kind_t event_kind;
	vtx_t  depth;
	vtx_t  from_vertex;
	vtx_t  to_vertex;
	logic  tree_edge;
	modport source (output valid, event_kind, depth, from_vertex, to_vertex, tree_edge,
		input ready);
	modport sink (input valid, event_kind, depth, from_vertex, to_vertex, tree_edge,
		output ready);
endinterface

interface dew_cfg_if;
	import dew_pkg::*;
	logic valid;
	logic ready;
	cnt_t vertex_count;
	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

/* sv/dew_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dew_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/dew_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_ctrl
// Sequencer for the walker: decodes commands and steps the walk datapath.
// ----------------------------------------------------------------------------
module dew_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  dew_pkg::func_t    in_func,
	output logic              in_ready,
	output dew_pkg::dew_cmd_t cmd,
	input  dew_pkg::dew_sts_t sts
);
	import dew_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_STEP_START,
		ST_CHECK,
		ST_ROOT,
		ST_ROW_RD,
		ST_SCAN,
		ST_POP_LD
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (in_func)
						FUNC_CLEAR: cmd.clear = 1'b1;
						FUNC_ADD:   state_nxt = ST_ADD_RD;
						FUNC_STEP:  state_nxt = ST_STEP_START;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				if (sts.add_ok) begin
					cmd.adj_rd_src = 1'b1;
					state_nxt = ST_ADD_WR;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_STEP_START: begin
				if (sts.out_free) begin
					if (sts.phase_done) begin
						cmd.emit_done = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						cmd.step_init = sts.phase_idle;
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				state_nxt = sts.level_zero ? ST_ROOT : ST_ROW_RD;
			end
			ST_ROOT: begin
				if (sts.root_end) begin
					cmd.emit_done = 1'b1;
					state_nxt = ST_IDLE;
				end else if (sts.root_hit) begin
					cmd.root_take = 1'b1;
					state_nxt = ST_ROW_RD;
				end else begin
					cmd.root_adv = 1'b1;
				end
			end
			ST_ROW_RD: begin
				cmd.adj_rd_top = 1'b1;
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.cur_end) begin
					cmd.pop = 1'b1;
					state_nxt = sts.pop_last ? ST_IDLE : ST_POP_LD;
				end else if (sts.row_hit) begin
					cmd.edge_emit = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			ST_POP_LD: begin
				cmd.top_ld = 1'b1;
				state_nxt = ST_ROW_RD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* sv/dew_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_datapath
// Adjacency memory, visit marks, explicit stack and the event register.
// ----------------------------------------------------------------------------
module dew_datapath #(
	parameter int MAX_VERTICES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dew_pkg::dew_cmd_t cmd,
	output dew_pkg::dew_sts_t sts,
	input  dew_pkg::vtx_t     src_vertex,
	input  dew_pkg::vtx_t     dst_vertex,
	input  logic              cfg_valid,
	input  dew_pkg::cnt_t     cfg_count,
	input  logic              out_ready,
	output logic              out_valid,
	output dew_pkg::kind_t    out_kind,
	output dew_pkg::vtx_t     out_depth,
	output dew_pkg::vtx_t     out_from,
	output dew_pkg::vtx_t     out_to,
	output logic              out_tree
);
	import dew_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int SW = VW + CW;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_DONE
	} phase_t;

	phase_t                  phase_q;
	vtx_t                    src_q;
	vtx_t                    dst_q;
	cnt_t                    vcount_q;
	logic [MAX_VERTICES-1:0] adj_valid_q;
	logic [MAX_VERTICES-1:0] unvisited_q;
	logic [CW-1:0]           level_q;
	logic [CW-1:0]           root_cur_q;
	logic [VW-1:0]           top_v_q;
	logic [CW-1:0]           top_cur_q;
	logic [VW-1:0]           root_v_q;
	logic                    out_valid_q;
	kind_t                   out_kind_q;
	vtx_t                    out_depth_q;
	vtx_t                    out_from_q;
	vtx_t                    out_to_q;
	logic                    out_tree_q;

	logic [CW-1:0]           n_act;
	logic [VW-1:0]           src_idx;
	logic [VW-1:0]           dst_idx;
	logic [VW-1:0]           cur_idx;
	logic [VW-1:0]           root_idx;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic [MAX_VERTICES-1:0] row;
	logic [VW-1:0]           adj_raddr;
	logic [SW-1:0]           stk_rdata;
	logic [SW-1:0]           stk_wdata;
	logic                    stk_we;
	logic                    tree;
	logic                    push;
	logic [CW-1:0]           cur_next;

	assign n_act = (32'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_q);
	assign src_idx = VW'(src_q);
	assign dst_idx = VW'(dst_q);
	assign cur_idx = top_cur_q[VW-1:0];
	assign root_idx = root_cur_q[VW-1:0];
	assign cur_next = CW'(top_cur_q + 1'b1);
	assign tree = unvisited_q[cur_idx];
	assign push = tree && (level_q != CW'(MAX_VERTICES));

	assign adj_raddr = cmd.adj_rd_src ? src_idx : top_v_q;
	assign adj_wdata = (adj_valid_q[src_idx] ? adj_rdata : '0)
		| (MAX_VERTICES'(1) << dst_idx);
	assign row = adj_valid_q[top_v_q] ? adj_rdata : '0;

	dew_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_adj_ram (
		.clk  (clk),
		.we   (cmd.add_wr),
		.waddr(src_idx),
		.wdata(adj_wdata),
		.re   (cmd.adj_rd_src | cmd.adj_rd_top),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	// The top of the stack lives in registers; the RAM holds the levels below it.
	assign stk_we = cmd.edge_emit & push;
	assign stk_wdata = {top_v_q, cur_next};

	dew_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_VERTICES)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(VW'(level_q - 1'b1)),
		.wdata(stk_wdata),
		.re   (cmd.pop),
		.raddr(VW'(level_q - 2'd2)),
		.rdata(stk_rdata)
	);

	always_comb begin
		sts = '0;
		sts.phase_idle = (phase_q == PH_IDLE);
		sts.phase_done = (phase_q == PH_DONE);
		sts.add_ok     = (32'(src_q) < MAX_VERTICES) && (32'(dst_q) < MAX_VERTICES);
		sts.out_free   = !out_valid_q || out_ready;
		sts.level_zero = (level_q == '0);
		sts.cur_end    = (top_cur_q >= n_act);
		sts.row_hit    = row[cur_idx];
		sts.pop_last   = (level_q == CW'(1));
		sts.root_end   = (root_cur_q >= n_act);
		sts.root_hit   = unvisited_q[root_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			src_q <= src_vertex;
			dst_q <= dst_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			vcount_q    <= cnt_t'(1);
			adj_valid_q <= '0;
			unvisited_q <= '0;
			level_q     <= '0;
			root_cur_q  <= '0;
			top_v_q     <= '0;
			top_cur_q   <= '0;
			root_v_q    <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= EVT_WALK_DONE;
			out_depth_q <= '0;
			out_from_q  <= '0;
			out_to_q    <= '0;
			out_tree_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vcount_q <= cfg_count;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				adj_valid_q <= '0;
				unvisited_q <= '0;
				level_q     <= '0;
				root_cur_q  <= '0;
				phase_q     <= PH_IDLE;
			end
			if (cmd.add_wr) begin
				adj_valid_q[src_idx] <= 1'b1;
				unvisited_q <= unvisited_q | (MAX_VERTICES'(1) << src_idx)
					| (MAX_VERTICES'(1) << dst_idx);
				if (phase_q == PH_DONE) begin
					phase_q <= PH_IDLE;
				end
			end
			if (cmd.step_init) begin
				root_cur_q <= '0;
				level_q    <= '0;
				phase_q    <= PH_RUN;
			end
			if (cmd.emit_done) begin
				phase_q     <= PH_DONE;
				out_valid_q <= 1'b1;
				out_kind_q  <= EVT_WALK_DONE;
				out_depth_q <= '0;
				out_from_q  <= '0;
				out_to_q    <= '0;
				out_tree_q  <= 1'b0;
			end
			if (cmd.root_adv) begin
				root_cur_q <= CW'(root_cur_q + 1'b1);
			end
			if (cmd.root_take) begin
				unvisited_q[root_idx] <= 1'b0;
				root_cur_q <= CW'(root_cur_q + 1'b1);
				level_q    <= CW'(1);
				top_v_q    <= root_idx;
				top_cur_q  <= '0;
				root_v_q   <= root_idx;
			end
			if (cmd.scan_adv) begin
				top_cur_q <= cur_next;
			end
			if (cmd.edge_emit) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= EVT_EDGE;
				out_depth_q <= vtx_t'(level_q - 1'b1);
				out_from_q  <= vtx_t'(top_v_q);
				out_to_q    <= vtx_t'(cur_idx);
				out_tree_q  <= tree;
				if (tree) begin
					unvisited_q[cur_idx] <= 1'b0;
				end
				if (push) begin
					top_v_q   <= cur_idx;
					top_cur_q <= '0;
					level_q   <= CW'(level_q + 1'b1);
				end else begin
					top_cur_q <= cur_next;
				end
			end
			if (cmd.pop) begin
				level_q <= CW'(level_q - 1'b1);
				if (level_q == CW'(1)) begin
					out_valid_q <= 1'b1;
					out_kind_q  <= EVT_COMP_DONE;
					out_depth_q <= '0;
					out_from_q  <= vtx_t'(root_v_q);
					out_to_q    <= '0;
					out_tree_q  <= 1'b0;
				end
			end
			if (cmd.top_ld) begin
				top_v_q   <= stk_rdata[SW-1:CW];
				top_cur_q <= stk_rdata[CW-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_depth = out_depth_q;
	assign out_from  = out_from_q;
	assign out_to    = out_to_q;
	assign out_tree  = out_tree_q;

endmodule

/* sv/dfs_edge_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_walker
// Depth-first walk over a directed adjacency-bit matrix, one event per step.
// ----------------------------------------------------------------------------
// One beat is in work at a time. A step beat tests adjacency bits or root candidates one at a
// time, takes roots and pops levels until it emits an event; after walk done it emits walk done.
// Popping a deep stack rescans the rest of each row bit-serially before the next event.
// The event register lets a new beat enter while the previous event waits to be taken.
// Reset clears the matrix valid bits, the marks, the walk and sets vertex_count to 1.
module dfs_edge_walker #(
	parameter int MAX_VERTICES = 32
) (
	input logic      clk,
	input logic      arst_n,
	dew_cmd_if.sink  cmd,
	dew_evt_if.source evt,
	dew_cfg_if.sink  cfg
);
	import dew_pkg::*;

	dew_cmd_t dp_cmd;
	dew_sts_t dp_sts;

	assign cfg.ready = 1'b1;

	dew_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_func (cmd.func),
		.in_ready(cmd.ready),
		.cmd     (dp_cmd),
		.sts     (dp_sts)
	);

	dew_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.src_vertex(cmd.src_vertex),
		.dst_vertex(cmd.dst_vertex),
		.cfg_valid (cfg.valid),
		.cfg_count (cfg.vertex_count),
		.out_ready (evt.ready),
		.out_valid (evt.valid),
		.out_kind  (evt.event_kind),
		.out_depth (evt.depth),
		.out_from  (evt.from_vertex),
		.out_to    (evt.to_vertex),
		.out_tree  (evt.tree_edge)
	);

endmodule
